FILE: rtl/sar_pkg.sv
`default_nettype none

package sar_pkg;

    // Header size in front of every payload; fixed by the block format.
    localparam int HEADER_BYTES = 32;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_RESIZE  = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] request_bytes;
        logic [21:0] payload_offset;
        logic        has_block;
    } item_t;

    typedef struct packed {
        logic        success;
        logic [21:0] result_offset;
        logic        moved;
        logic [22:0] copy_bytes;
        logic [22:0] arena_end;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/sar_hdr_mem.sv
`default_nettype none

// Header store: one write port, one read port, registered read data.
// Read data holds while re is low.
module sar_hdr_mem #(
    parameter int W     = 41,
    parameter int DEPTH = 65536
) (
    input  wire logic                                     aclk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [W-1:0]                             wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [W-1:0]                             rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sar_seq.sv
`default_nettype none

// Request sequencer: decodes one request, reads/modifies/writes headers
// and walks freed headers down from the top of the stack.
module sar_seq #(
    parameter int ARENA_SIZE  = 4194304,
    parameter int ALIGN_BYTES = 64
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            item_valid,
    input  wire sar_pkg::item_t  item,
    output logic                 item_ready,
    output logic                 res_valid,
    output sar_pkg::result_t     res,
    input  wire logic            res_ready,
    output logic                                     mem_we,
    output logic [((ARENA_SIZE / ALIGN_BYTES > 1) ? $clog2(ARENA_SIZE / ALIGN_BYTES) : 1)-1:0]
                                                     mem_waddr,
    output logic [2 * $clog2(ARENA_SIZE + 1) + $clog2(ARENA_SIZE / ALIGN_BYTES + 1)
                  - $clog2(ARENA_SIZE + 1):0]        mem_wdata,
    output logic                                     mem_re,
    output logic [((ARENA_SIZE / ALIGN_BYTES > 1) ? $clog2(ARENA_SIZE / ALIGN_BYTES) : 1)-1:0]
                                                     mem_raddr,
    input  wire logic [2 * $clog2(ARENA_SIZE + 1) + $clog2(ARENA_SIZE / ALIGN_BYTES + 1)
                  - $clog2(ARENA_SIZE + 1):0]        mem_rdata
);

    localparam int DEPTH  = ARENA_SIZE / ALIGN_BYTES;
    localparam int SH     = $clog2(ALIGN_BYTES);
    localparam int END_W  = $clog2(ARENA_SIZE + 1);
    localparam int SIZE_W = END_W;
    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = END_W + 2;
    localparam int ENT_W  = SIZE_W + IDX_W + 1;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECODE   = 7'b0000010,
        S_HDR      = 7'b0000100,
        S_REL      = 7'b0001000,
        S_WALK_RD  = 7'b0010000,
        S_WALK_CHK = 7'b0100000,
        S_EMIT     = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [END_W-1:0]     used_end_reg, used_end_next;
    logic [IDX_W-1:0]     top_reg, top_next;
    sar_pkg::item_t       item_reg;
    logic                 ok_reg, ok_next;
    logic [21:0]          off_reg, off_next;
    logic                 moved_reg, moved_next;
    logic [22:0]          copy_reg, copy_next;

    // request decode
    logic                 n_big;
    logic [SIZE_W-1:0]    n_sz;
    logic [SUM_W-1:0]     tsum, need, fit_sum, top_end;
    logic [31:0]          nb32, new_pay32;
    logic [IDX_W-1:0]     new_idx;
    logic                 alloc_ok;
    logic [21:0]          poff_m;
    logic [31:0]          slot32, slot_base32, slot_pay32, top_base32, copy32;
    logic                 slot_ok, top_fit, is_alloc;
    logic [IDX_W-1:0]     slot_idx;
    logic [SIZE_W-1:0]    rd_size, min_sz;
    logic [IDX_W-1:0]     rd_below;
    logic                 rd_freed;
    logic [31:0]          used32;

    assign rd_size  = mem_rdata[SIZE_W-1:0];
    assign rd_below = mem_rdata[SIZE_W+IDX_W-1:SIZE_W];
    assign rd_freed = mem_rdata[ENT_W-1];

    always_comb begin
        n_big     = item_reg.request_bytes > 32'(ARENA_SIZE);
        n_sz      = item_reg.request_bytes[SIZE_W-1:0];
        // header plus payload, rounded up to the alignment
        tsum      = SUM_W'(n_sz) + SUM_W'(sar_pkg::HEADER_BYTES + ALIGN_BYTES - 1);
        need      = (tsum >> SH) << SH;
        fit_sum   = SUM_W'(used_end_reg) + need;
        nb32      = 32'(used_end_reg) >> SH;
        new_idx   = nb32[IDX_W-1:0];
        alloc_ok  = !n_big && (fit_sum <= SUM_W'(ARENA_SIZE)) && (nb32 < 32'(DEPTH));
        new_pay32 = (32'(new_idx) << SH) + 32'(sar_pkg::HEADER_BYTES);

        poff_m      = item_reg.payload_offset - 22'(sar_pkg::HEADER_BYTES);
        slot32      = 32'(poff_m) >> SH;
        slot_ok     = (item_reg.payload_offset >= 22'(sar_pkg::HEADER_BYTES))
                      && (slot32 < 32'(DEPTH));
        slot_idx    = slot32[IDX_W-1:0];
        slot_base32 = 32'(slot_idx) << SH;
        slot_pay32  = slot_base32 + 32'(sar_pkg::HEADER_BYTES);
        top_end     = SUM_W'(slot_base32) + need;
        top_fit     = !n_big && (top_end <= SUM_W'(ARENA_SIZE));
        top_base32  = 32'(top_reg) << SH;

        is_alloc = (item_reg.func == sar_pkg::FUNC_ALLOC)
                   || ((item_reg.func == sar_pkg::FUNC_RESIZE) && !item_reg.has_block);
        min_sz   = (rd_size < n_sz) ? rd_size : n_sz;
        copy32   = 32'(min_sz);
        used32   = 32'(used_end_reg);
    end

    always_comb begin
        state_next    = state_reg;
        used_end_next = used_end_reg;
        top_next      = top_reg;
        ok_next       = ok_reg;
        off_next      = off_reg;
        moved_next    = moved_reg;
        copy_next     = copy_reg;
        mem_we        = 1'b0;
        mem_waddr     = slot_idx[ADDR_W-1:0];
        mem_wdata     = {1'b1, rd_below, rd_size};
        mem_re        = 1'b0;
        mem_raddr     = slot_idx[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (item_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                ok_next    = 1'b0;
                off_next   = '0;
                moved_next = 1'b0;
                copy_next  = '0;
                state_next = S_EMIT;
                if (is_alloc) begin
                    if (alloc_ok) begin
                        mem_we        = 1'b1;
                        mem_waddr     = new_idx[ADDR_W-1:0];
                        mem_wdata     = {1'b0, top_reg, n_sz};
                        top_next      = new_idx;
                        used_end_next = fit_sum[END_W-1:0];
                        ok_next       = 1'b1;
                        off_next      = new_pay32[21:0];
                    end
                end else if (item_reg.func == sar_pkg::FUNC_RELEASE) begin
                    ok_next = 1'b1;
                    if (item_reg.has_block && slot_ok) begin
                        mem_re     = 1'b1;
                        state_next = S_HDR;
                    end
                end else if (item_reg.func == sar_pkg::FUNC_RESIZE) begin
                    if (slot_ok) begin
                        mem_re     = 1'b1;
                        state_next = S_HDR;
                    end
                end
            end
            S_HDR: begin
                state_next = S_EMIT;
                if (item_reg.func == sar_pkg::FUNC_RELEASE) begin
                    mem_we     = 1'b1;
                    state_next = S_WALK_RD;
                end else if (slot_idx == top_reg) begin
                    // top block: grow or shrink in place
                    if (top_fit) begin
                        mem_we        = 1'b1;
                        mem_wdata     = {rd_freed, rd_below, n_sz};
                        used_end_next = top_end[END_W-1:0];
                        ok_next       = 1'b1;
                        off_next      = slot_pay32[21:0];
                    end
                end else if (alloc_ok) begin
                    // move: new block on top, old one released next;
                    // a new block placed on the old (stale) slot is freed at once
                    mem_we        = 1'b1;
                    mem_waddr     = new_idx[ADDR_W-1:0];
                    mem_wdata     = {(new_idx == slot_idx), top_reg, n_sz};
                    top_next      = new_idx;
                    used_end_next = fit_sum[END_W-1:0];
                    ok_next       = 1'b1;
                    off_next      = new_pay32[21:0];
                    moved_next    = 1'b1;
                    copy_next     = copy32[22:0];
                    state_next    = S_REL;
                end
            end
            S_REL: begin
                // rdata still holds the old header; nothing left to mark when
                // the new block took over the old slot
                mem_we     = (slot_idx != top_reg);
                state_next = S_WALK_RD;
            end
            S_WALK_RD: begin
                if (32'(top_reg) >= 32'(DEPTH)) begin
                    state_next = S_EMIT;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = top_reg[ADDR_W-1:0];
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                if (rd_freed) begin
                    used_end_next = top_base32[END_W-1:0];
                    top_next      = rd_below;
                    state_next    = S_WALK_RD;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign item_ready        = (state_reg == S_IDLE);
    assign res_valid         = (state_reg == S_EMIT);
    assign res.success       = ok_reg;
    assign res.result_offset = off_reg;
    assign res.moved         = moved_reg;
    assign res.copy_bytes    = copy_reg;
    assign res.arena_end     = used32[22:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            used_end_reg <= '0;
            top_reg      <= IDX_W'(DEPTH);
        end else begin
            state_reg    <= state_next;
            used_end_reg <= used_end_next;
            top_reg      <= top_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_valid && item_ready) begin
            item_reg <= item;
        end
        ok_reg    <= ok_next;
        off_reg   <= off_next;
        moved_reg <= moved_next;
        copy_reg  <= copy_next;
    end

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re && (mem_waddr == mem_raddr)))
        else $error("header read and write hit the same entry");

    a_ready_excludes_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !(item_ready && res_valid))
        else $error("new request taken while a result is pending");

    a_end_in_arena: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(used_end_reg) <= 32'(ARENA_SIZE))
        else $error("arena end beyond arena size");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_DECODE || state_reg == S_HDR || state_reg == S_REL))
        else $error("header write outside a modify step");

endmodule

`default_nettype wire

FILE: rtl/stack_arena_allocator.sv
// Stack arena allocator with deferred free.
// Slave channel (s_*) takes one request per transaction: s_tuser carries the
// function code and the has_block flag, s_tdata the byte count and payload
// offset. Master channel (m_*) returns exactly one result per request, in
// order: success and moved in m_tuser, offsets and sizes in m_tdata.
// Requests are processed one at a time by a sequencer around a single
// header memory (one write, one registered read port).
// Releases and resizes with move mark the old header freed and then walk
// freed headers down from the top of the stack, one header read per step.
// A new request can be accepted in the cycle after the previous result
// enters the output register.
// The output register decouples the channels: while m_tready is low the
// result holds and the next request is still accepted and processed; the
// sequencer then waits with its result until the register frees up.
// Reset clears arena end and top-of-stack marker; the header memory is not
// cleared.
// ALIGN_BYTES must be a power of two.
`default_nettype none

module stack_arena_allocator #(
    parameter int ARENA_SIZE  = 4194304,
    parameter int ALIGN_BYTES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,  // request_bytes[31:0], payload_offset[53:32], pad
    input  wire logic [2:0]  s_tuser,  // func[1:0], has_block[2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata,  // result_offset[21:0], copy_bytes[44:22],
                                       // arena_end[67:45], pad
    output logic      [1:0]  m_tuser   // success[0], moved[1]
);

    localparam int DEPTH  = ARENA_SIZE / ALIGN_BYTES;
    localparam int END_W  = $clog2(ARENA_SIZE + 1);
    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENT_W  = END_W + IDX_W + 1;   // size, below, freed

    sar_pkg::item_t   item;
    sar_pkg::result_t res;
    logic             res_valid, res_ready;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [ENT_W-1:0]  mem_wdata, mem_rdata;

    // output register
    logic             m_tvalid_reg, m_tvalid_next;
    sar_pkg::result_t out_reg;

    assign item.func           = s_tuser[1:0];
    assign item.has_block      = s_tuser[2];
    assign item.request_bytes  = s_tdata[31:0];
    assign item.payload_offset = s_tdata[53:32];

    sar_seq #(
        .ARENA_SIZE (ARENA_SIZE),
        .ALIGN_BYTES(ALIGN_BYTES)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_valid(s_tvalid),
        .item      (item),
        .item_ready(s_tready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    sar_hdr_mem #(
        .W    (ENT_W),
        .DEPTH(DEPTH)
    ) u_mem (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // register is free when empty or being drained this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign m_tuser[0]     = out_reg.success;
    assign m_tuser[1]     = out_reg.moved;
    assign m_tdata[21:0]  = out_reg.result_offset;
    assign m_tdata[44:22] = out_reg.copy_bytes;
    assign m_tdata[67:45] = out_reg.arena_end;
    assign m_tdata[71:68] = 4'd0;

endmodule

`default_nettype wire
